@@ rtl/core/cctt_pkg.sv @@
// ----------------------------------------------------------------------------
// cctt_pkg
// Shared types, codes and the default character class table of the tokenizer.
// ----------------------------------------------------------------------------
package cctt_pkg;

  localparam int LENGTH_WIDTH = 15;   // token length counter
  localparam int LIMIT_W      = 15;   // limit register width
  localparam int CLS_W        = 6;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // class bit positions
  localparam int C_WS = 0;
  localparam int C_WC = 1;
  localparam int C_QT = 2;
  localparam int C_NS = 3;
  localparam int C_NC = 4;
  localparam int C_SY = 5;

  typedef enum logic [1:0] {
    ACT_TEXT  = 2'd0,
    ACT_EOT   = 2'd1,
    ACT_RULE  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RULE_WS  = 3'd0,
    RULE_WC  = 3'd1,
    RULE_QT  = 3'd2,
    RULE_NS  = 3'd3,
    RULE_NC  = 3'd4,
    RULE_SY  = 3'd5,
    RULE_IGN = 3'd6
  } rule_t;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_STR  = 2'd1,
    KIND_NUM  = 2'd2,
    KIND_SYM  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_WORD = 5'b00010,
    M_STR  = 5'b00100,
    M_PEND = 5'b01000,
    M_NUM  = 5'b10000
  } mode_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             eot;
    logic [7:0]       data;
    logic [CLS_W-1:0] cls;
  } tok_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       token_end;
    logic       overflow;
  } res_t;

  function automatic logic [CLS_W-1:0] default_class(input logic [7:0] b);
    logic [CLS_W-1:0] c;
    c = '0;
    if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
      c[C_WS] = 1'b1;
      c[C_WC] = 1'b1;
    end else if (b inside {[8'h30:8'h39]}) begin
      c[C_WC] = 1'b1;
      c[C_NS] = 1'b1;
      c[C_NC] = 1'b1;
    end else if (b == 8'h22) begin
      c[C_QT] = 1'b1;
    end else if (b inside {8'h2B, 8'h2D}) begin
      c[C_NS] = 1'b1;
    end else if (b == 8'h2E) begin
      c[C_NC] = 1'b1;
    end else if (b == 8'h0A) begin
      c[C_SY] = 1'b1;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/char_class_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// char_class_text_tokenizer
// Character class lexer: front (table lookup, rule writes, clears), queue, back
// (token scanner with length limits and output register).
// ----------------------------------------------------------------------------
// Path: front stage 1 register, queue entry, then result output register.
// Throughput: one item per cycle unless the output stalls; an item with two
//   results (token end, new token's first byte) holds the back for the second.
// Class table: 256x6 memory, registered lookup, RMW rule writes in stage 1.
// Reset: synchronous; table reads as the default sets at once through
//   per-entry valid bits, so no clearing pass is needed.
module char_class_text_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_value, [10:8] rule, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [8] overflow, rest zero
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] has_byte
  output logic        out_tlast   // token_end
);
  import cctt_pkg::*;

  logic  push;
  tok_t  push_tok;
  logic  q_full;
  logic  head_valid;
  tok_t  head_tok;
  logic  pop;
  res_t  res;

  cctt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (action_t'(in_tuser)),
    .in_byte   (in_tdata[7:0]),
    .in_rule   (in_tdata[10:8]),
    .push      (push),
    .push_tok  (push_tok),
    .q_full    (q_full)
  );

  cctt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop)
  );

  cctt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {7'd0, res.overflow, res.data_byte};
  assign out_tuser = {res.has_byte, res.kind};
  assign out_tlast = res.token_end;

endmodule

@@ rtl/core/cctt_front.sv @@
// ----------------------------------------------------------------------------
// cctt_front
// Accepts input transactions, looks up the class table and applies rule
// writes and clears. Text and end-of-text items go on to the queue.
// ----------------------------------------------------------------------------
module cctt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cctt_pkg::action_t in_action,
  input  logic [7:0]       in_byte,
  input  logic [2:0]       in_rule,
  output logic             push,
  output cctt_pkg::tok_t   push_tok,
  input  logic             q_full
);
  import cctt_pkg::*;

  logic [CLS_W-1:0] mem [256];
  logic [255:0]     valid_r;
  logic             cleared_r;

  logic             s1_valid_r;
  action_t          s1_action_r;
  logic [7:0]       s1_byte_r;
  logic [2:0]       s1_rule_r;
  logic [CLS_W-1:0] mem_rd_r;
  logic             fwd_hit_r;
  logic [CLS_W-1:0] fwd_data_r;

  logic             is_cfg;
  logic             retire;
  logic             in_acc;
  logic [CLS_W-1:0] cls_eff;
  logic [CLS_W-1:0] add_m;
  logic [CLS_W-1:0] rem_m;
  logic             wr_en;
  logic             clr_en;
  logic [CLS_W-1:0] wr_data;

  assign is_cfg   = (s1_action_r == ACT_RULE) || (s1_action_r == ACT_CLEAR);
  assign retire   = s1_valid_r && (is_cfg || !q_full);
  assign in_ready = !s1_valid_r || retire;
  assign in_acc   = in_valid && in_ready;

  // a write in the cycle of the lookup is not in mem_rd_r yet
  always_comb begin
    if (fwd_hit_r) begin
      cls_eff = fwd_data_r;
    end else if (valid_r[s1_byte_r]) begin
      cls_eff = mem_rd_r;
    end else if (cleared_r) begin
      cls_eff = '0;
    end else begin
      cls_eff = default_class(s1_byte_r);
    end
  end

  always_comb begin
    add_m = '0;
    rem_m = '0;
    wr_en = 1'b0;
    case (s1_rule_r)
      RULE_WS: begin
        add_m[C_WS] = 1'b1;
        rem_m[C_QT] = 1'b1; rem_m[C_NS] = 1'b1; rem_m[C_SY] = 1'b1;
        wr_en = 1'b1;
      end
      RULE_WC: begin
        add_m[C_WC] = 1'b1;
        wr_en = 1'b1;
      end
      RULE_QT: begin
        add_m[C_QT] = 1'b1;
        rem_m[C_WS] = 1'b1; rem_m[C_NS] = 1'b1; rem_m[C_SY] = 1'b1;
        wr_en = 1'b1;
      end
      RULE_NS: begin
        add_m[C_NS] = 1'b1;
        rem_m[C_QT] = 1'b1; rem_m[C_WS] = 1'b1; rem_m[C_SY] = 1'b1;
        wr_en = 1'b1;
      end
      RULE_NC: begin
        add_m[C_NC] = 1'b1;
        wr_en = 1'b1;
      end
      RULE_SY: begin
        add_m[C_SY] = 1'b1;
        rem_m = ~add_m;
        wr_en = 1'b1;
      end
      RULE_IGN: begin
        rem_m[C_WS] = 1'b1; rem_m[C_QT] = 1'b1; rem_m[C_NS] = 1'b1; rem_m[C_SY] = 1'b1;
        wr_en = 1'b1;
      end
      default: wr_en = 1'b0;
    endcase
    wr_en   = wr_en && s1_valid_r && (s1_action_r == ACT_RULE);
    wr_data = (cls_eff | add_m) & ~rem_m;
  end

  assign clr_en = s1_valid_r && (s1_action_r == ACT_CLEAR);

  assign push          = s1_valid_r && !is_cfg && !q_full;
  assign push_tok.eot  = (s1_action_r == ACT_EOT);
  assign push_tok.data = s1_byte_r;
  assign push_tok.cls  = cls_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      valid_r    <= '0;
      cleared_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
      if (clr_en) begin
        valid_r   <= '0;
        cleared_r <= 1'b1;
      end else if (wr_en) begin
        valid_r[s1_byte_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_byte;
      s1_rule_r   <= in_rule;
      mem_rd_r    <= mem[in_byte];
      fwd_hit_r   <= wr_en && (s1_byte_r == in_byte);
      fwd_data_r  <= wr_data;
    end
    if (wr_en) begin
      mem[s1_byte_r] <= wr_data;
    end
  end

endmodule

@@ rtl/core/cctt_queue.sv @@
// ----------------------------------------------------------------------------
// cctt_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cctt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cctt_pkg::tok_t push_tok,
  output logic           full,
  output logic           head_valid,
  output cctt_pkg::tok_t head_tok,
  input  logic           pop
);
  import cctt_pkg::*;

  tok_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_tok   = ent_r[rp_r];

  function automatic logic [QPTR_W-1:0] inc_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc_ptr(wp_r);
      if (pop)  rp_r <= inc_ptr(rp_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_tok;
  end

endmodule

@@ rtl/core/cctt_back.sv @@
// ----------------------------------------------------------------------------
// cctt_back
// Token scanner: mode, length count, limits and result output register.
// An item that gives two results holds the second in a pending register.
// ----------------------------------------------------------------------------
module cctt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [cctt_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                         head_valid,
  input  cctt_pkg::tok_t               head_tok,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cctt_pkg::res_t               out_res
);
  import cctt_pkg::*;

  localparam int CMP_W = (LENGTH_WIDTH > LIMIT_W) ? LENGTH_WIDTH : LIMIT_W;
  localparam logic [LENGTH_WIDTH-1:0] LEN_TOP = '1;

  localparam logic [1:0] REG_WORD = 2'd0;
  localparam logic [1:0] REG_STR  = 2'd1;
  localparam logic [1:0] REG_NUM  = 2'd2;

  mode_t                   mode_r, mode_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic                    drop_r, drop_nxt;
  logic [LIMIT_W-1:0]      word_lim_r, str_lim_r, num_lim_r;
  logic                    out_valid_r;
  res_t                    out_r;
  logic                    pend_valid_r;
  res_t                    pend_r;

  logic       slot_free;
  res_t       r0, r1;
  logic [1:0] n_res;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = slot_free && !pend_valid_r && head_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    kind_t              cur_kind;
    logic [LIMIT_W-1:0] cur_lim;
    logic               keep_ok;
    logic               do_keep;
    logic               do_end;
    logic               do_start;
    logic               emit;
    res_t               sres;
    logic [CLS_W-1:0]   c;

    c        = head_tok.cls;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    drop_nxt = drop_r;
    n_res    = 2'd0;
    r0       = '0;
    r1       = '0;
    sres     = '0;
    emit     = 1'b0;
    do_keep  = 1'b0;
    do_end   = 1'b0;
    do_start = 1'b0;

    case (mode_r)
      M_WORD: begin cur_kind = KIND_WORD; cur_lim = word_lim_r; end
      M_NUM:  begin cur_kind = KIND_NUM;  cur_lim = num_lim_r;  end
      default: begin cur_kind = KIND_STR; cur_lim = str_lim_r;  end
    endcase
    keep_ok = (CMP_W'(len_r) < CMP_W'(cur_lim)) && (len_r != LEN_TOP);

    if (head_tok.eot) begin
      do_end = (mode_r != M_IDLE);
    end else begin
      case (mode_r)
        M_WORD: begin
          if (c[C_WC]) do_keep = 1'b1;
          else begin do_end = 1'b1; do_start = 1'b1; end
        end
        M_NUM: begin
          if (c[C_NC]) do_keep = 1'b1;
          else begin do_end = 1'b1; do_start = 1'b1; end
        end
        M_STR: begin
          if (c[C_QT]) mode_nxt = M_PEND;
          else do_keep = 1'b1;
        end
        M_PEND: begin
          // doubled quote: one literal quote byte
          if (c[C_QT]) begin
            mode_nxt = M_STR;
            do_keep  = 1'b1;
          end else begin
            do_end = 1'b1; do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    if (do_keep) begin
      if (keep_ok) begin
        r0.kind      = cur_kind;
        r0.data_byte = head_tok.data;
        r0.has_byte  = 1'b1;
        n_res        = 2'd1;
        len_nxt      = len_r + 1'b1;
      end else begin
        drop_nxt = 1'b1;
      end
    end

    if (do_end) begin
      r0.kind      = cur_kind;
      r0.token_end = 1'b1;
      r0.overflow  = drop_r;
      n_res        = 2'd1;
    end

    if (do_end || do_start) begin
      mode_nxt = M_IDLE;
      len_nxt  = '0;
      drop_nxt = 1'b0;
    end

    if (do_start) begin
      sres.data_byte = head_tok.data;
      sres.has_byte  = 1'b1;
      if (c[C_QT]) begin
        mode_nxt = M_STR;
      end else if (c[C_WS]) begin
        mode_nxt  = M_WORD;
        sres.kind = KIND_WORD;
        emit      = (word_lim_r != '0);
      end else if (c[C_NS]) begin
        mode_nxt  = M_NUM;
        sres.kind = KIND_NUM;
        emit      = (num_lim_r != '0);
      end else if (c[C_SY]) begin
        sres.kind      = KIND_SYM;
        sres.token_end = 1'b1;
        emit           = 1'b1;
      end
      if ((c[C_WS] || c[C_NS]) && !c[C_QT]) begin
        if (emit) len_nxt  = LENGTH_WIDTH'(1);
        else      drop_nxt = 1'b1;
      end
      if (emit) begin
        if (n_res == 2'd0) begin
          r0    = sres;
          n_res = 2'd1;
        end else begin
          r1    = sres;
          n_res = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      len_r        <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      word_lim_r   <= LIMIT_W'(511);
      str_lim_r    <= LIMIT_W'(24575);
      num_lim_r    <= LIMIT_W'(127);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WORD: word_lim_r <= cfg_wdata;
          REG_STR:  str_lim_r  <= cfg_wdata;
          REG_NUM:  num_lim_r  <= cfg_wdata;
          default:  ;
        endcase
      end
      if (slot_free) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else if (head_valid) begin
          mode_r       <= mode_nxt;
          len_r        <= len_nxt;
          drop_r       <= drop_nxt;
          out_valid_r  <= (n_res != 2'd0);
          pend_valid_r <= (n_res == 2'd2);
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else begin
        out_r  <= r0;
        pend_r <= r1;
      end
    end
  end

endmodule

@@ rtl/core/cctt_checker.sv @@
// ----------------------------------------------------------------------------
// cctt_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
module cctt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import cctt_pkg::*;

  // a stalled transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // symbols are single complete results without overflow
  a_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_SYM) |->
      out_tlast && out_tuser[2] && !out_tdata[8])
    else $error("bad symbol result");

  // end markers carry no byte; token bytes never carry overflow
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != KIND_SYM) |->
      (out_tlast == !out_tuser[2]) &&
      (out_tlast || !out_tdata[8]) &&
      (!out_tlast || (out_tdata[7:0] == 8'd0)))
    else $error("bad token byte or end marker");

endmodule

bind char_class_text_tokenizer cctt_checker u_cctt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ bench/tb_char_class_text_tokenizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_class_text_tokenizer
// Self-checking bench for the character class lexer. A behavioral lexer in
// the bench predicts every token byte and end marker; a monitor compares
// each output transaction against the oldest prediction. Covers the default
// classes, rule writes, table clears, length limits from zero to full range,
// random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------
module tb_char_class_text_tokenizer;
  import cctt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 8;      // pipeline latency plus margin
  localparam int LEN_TOP     = (1 << LENGTH_WIDTH) - 1;

  localparam logic [1:0] REG_WORD_LIMIT   = 2'd0;
  localparam logic [1:0] REG_STRING_LIMIT = 2'd1;
  localparam logic [1:0] REG_NUMBER_LIMIT = 2'd2;

  localparam string WORD_START = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  localparam string WORD_BODY  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_STR, SCAN_PEND, SCAN_NUM
  } scan_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] byte_value, [10:8] rule
  logic [1:0]  in_tuser = '0;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] data_byte, [8] overflow
  logic [2:0]  out_tuser;       // [1:0] kind, [2] has_byte
  logic        out_tlast;       // token_end

  char_class_text_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // lexer state mirrored in the bench
  logic [5:0]  cls_tbl [256];
  scan_t       scan;
  int unsigned tok_len;
  bit          dropped;
  logic [14:0] word_lim, string_lim, number_lim;

  res_t token_bytes_q [$];

  int  errors = 0;
  int  items_sent;
  int  results_checked = 0;
  int  cycles = 0;
  bit  tx_idle;
  bit  rx_idle;
  int  rx_hold;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("char_class_text_tokenizer: mismatch");
      $finish;
    end
  end

  // ---------------- lexer prediction ----------------

  function automatic void load_default_classes();
    foreach (cls_tbl[i]) cls_tbl[i] = '0;
    for (int i = "A"; i <= "Z"; i++) begin
      cls_tbl[i][C_WS] = 1'b1;
      cls_tbl[i][C_WC] = 1'b1;
    end
    for (int i = "a"; i <= "z"; i++) begin
      cls_tbl[i][C_WS] = 1'b1;
      cls_tbl[i][C_WC] = 1'b1;
    end
    cls_tbl["_"][C_WS] = 1'b1;
    cls_tbl["_"][C_WC] = 1'b1;
    for (int i = "0"; i <= "9"; i++) begin
      cls_tbl[i][C_WC] = 1'b1;
      cls_tbl[i][C_NS] = 1'b1;
      cls_tbl[i][C_NC] = 1'b1;
    end
    cls_tbl[8'h22][C_QT] = 1'b1;
    cls_tbl["+"][C_NS]   = 1'b1;
    cls_tbl["-"][C_NS]   = 1'b1;
    cls_tbl["."][C_NC]   = 1'b1;
    cls_tbl[8'h0A][C_SY] = 1'b1;
  endfunction

  function automatic void push_token_byte(kind_t k, logic [7:0] b, bit has, bit last, bit ovf);
    res_t r;
    r.kind      = k;
    r.data_byte = b;
    r.has_byte  = has;
    r.token_end = last;
    r.overflow  = ovf;
    token_bytes_q.push_back(r);
  endfunction

  function automatic kind_t open_kind();
    if (scan == SCAN_WORD) return KIND_WORD;
    if (scan == SCAN_NUM) return KIND_NUM;
    return KIND_STR;
  endfunction

  function automatic int unsigned open_limit();
    if (scan == SCAN_WORD) return word_lim;
    if (scan == SCAN_NUM) return number_lim;
    return string_lim;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (tok_len < open_limit() && tok_len < LEN_TOP) begin
      push_token_byte(open_kind(), b, 1'b1, 1'b0, 1'b0);
      tok_len++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void close_token();
    push_token_byte(open_kind(), 8'h00, 1'b0, 1'b1, dropped);
    scan    = SCAN_IDLE;
    tok_len = 0;
    dropped = 1'b0;
  endfunction

  function automatic void begin_token(logic [7:0] b);
    logic [5:0] c;
    c       = cls_tbl[b];
    scan    = SCAN_IDLE;
    tok_len = 0;
    dropped = 1'b0;
    if (c[C_QT]) begin
      scan = SCAN_STR;
    end else if (c[C_WS]) begin
      scan = SCAN_WORD;
      keep_byte(b);
    end else if (c[C_NS]) begin
      scan = SCAN_NUM;
      keep_byte(b);
    end else if (c[C_SY]) begin
      push_token_byte(KIND_SYM, b, 1'b1, 1'b1, 1'b0);
    end
  endfunction

  function automatic void apply_rule(logic [7:0] b, logic [2:0] r);
    logic [5:0] add, rem;
    add = '0;
    rem = '0;
    case (r)
      RULE_WS: begin
        add[C_WS] = 1'b1;
        rem[C_QT] = 1'b1; rem[C_NS] = 1'b1; rem[C_SY] = 1'b1;
      end
      RULE_WC: add[C_WC] = 1'b1;
      RULE_QT: begin
        add[C_QT] = 1'b1;
        rem[C_WS] = 1'b1; rem[C_NS] = 1'b1; rem[C_SY] = 1'b1;
      end
      RULE_NS: begin
        add[C_NS] = 1'b1;
        rem[C_QT] = 1'b1; rem[C_WS] = 1'b1; rem[C_SY] = 1'b1;
      end
      RULE_NC: add[C_NC] = 1'b1;
      RULE_SY: begin
        add = '0;
        add[C_SY] = 1'b1;
        rem = ~add;
      end
      RULE_IGN: begin
        rem[C_WS] = 1'b1; rem[C_QT] = 1'b1; rem[C_NS] = 1'b1; rem[C_SY] = 1'b1;
      end
      default: return;   // unused rule code leaves the entry alone
    endcase
    cls_tbl[b] = (cls_tbl[b] | add) & ~rem;
  endfunction

  function automatic void lex_step(action_t act, logic [7:0] b, logic [2:0] r);
    logic [5:0] c;
    c = cls_tbl[b];
    case (act)
      ACT_RULE:  apply_rule(b, r);
      ACT_CLEAR: foreach (cls_tbl[i]) cls_tbl[i] = '0;
      ACT_EOT:   if (scan != SCAN_IDLE) close_token();
      default: begin
        case (scan)
          SCAN_WORD:
            if (c[C_WC]) keep_byte(b);
            else begin
              close_token();
              begin_token(b);
            end
          SCAN_NUM:
            if (c[C_NC]) keep_byte(b);
            else begin
              close_token();
              begin_token(b);
            end
          SCAN_STR:
            if (c[C_QT]) scan = SCAN_PEND;
            else keep_byte(b);
          SCAN_PEND:
            if (c[C_QT]) begin   // doubled quote: one literal quote byte
              scan = SCAN_STR;
              keep_byte(b);
            end else begin
              close_token();
              begin_token(b);
            end
          default: begin_token(b);
        endcase
      end
    endcase
  endfunction

  // ---------------- output side ----------------

  task automatic check_token_byte();
    res_t want;
    if (token_bytes_q.size() == 0) begin
      $error("unexpected transaction: kind %0d byte %02h has %0b last %0b ovf %0b",
             out_tuser[1:0], out_tdata[7:0], out_tuser[2], out_tlast, out_tdata[8]);
      errors++;
    end else begin
      want = token_bytes_q.pop_front();
      if (out_tuser[1:0] !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, out_tuser[1:0]);
        errors++;
      end
      if (out_tdata[7:0] !== want.data_byte) begin
        $error("data_byte: expected %02h, got %02h", want.data_byte, out_tdata[7:0]);
        errors++;
      end
      if (out_tuser[2] !== want.has_byte) begin
        $error("has_byte: expected %0b, got %0b", want.has_byte, out_tuser[2]);
        errors++;
      end
      if (out_tlast !== want.token_end) begin
        $error("token_end: expected %0b, got %0b", want.token_end, out_tlast);
        errors++;
      end
      if (out_tdata[8] !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, out_tdata[8]);
        errors++;
      end
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_token_byte();
  end

  // receiver: random stall per transaction, or a long hold when requested
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ---------------- input side ----------------

  task automatic send_item(action_t act, logic [7:0] b, logic [2:0] r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, r, b};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    lex_step(act, b, r);
    items_sent++;
  endtask

  task automatic send_text(logic [7:0] b);
    send_item(ACT_TEXT, b, 3'($urandom_range(0, 7)));
  endtask

  task automatic send_eot();
    send_item(ACT_EOT, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (token_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // close any open token, let the pipe empty, then load all three limits
  task automatic load_limits(logic [14:0] w, logic [14:0] s, logic [14:0] n);
    send_eot();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WORD_LIMIT;
    cfg_wdata <= w;
    @(posedge clk);
    word_lim  = w;
    cfg_index <= REG_STRING_LIMIT;
    cfg_wdata <= s;
    @(posedge clk);
    string_lim = s;
    cfg_index <= REG_NUMBER_LIMIT;
    cfg_wdata <= n;
    @(posedge clk);
    number_lim = n;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // mostly well-formed tokens over the given classes, with some noise
  task automatic random_text(int n, string ws, string wc, string ns, string nc,
                             logic [7:0] qt, string sy, int max_len);
    int         start, p, len;
    logic [7:0] b;
    start = items_sent;
    while (items_sent - start < n) begin
      p   = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 6);
      if (p < 28) begin
        send_text(pick(ws));
        repeat (len - 1) send_text(pick(wc));
      end else if (p < 44) begin
        send_text(pick(ns));
        repeat (len - 1) send_text(pick(nc));
      end else if (p < 60) begin
        send_text(qt);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) begin
            send_text(qt);
            send_text(qt);
          end else begin
            do b = 8'($urandom_range(32, 126)); while (b == qt);
            send_text(b);
          end
        end
        if ($urandom_range(0, 9) != 0) send_text(qt);
      end else if (p < 68) begin
        send_text(pick(sy));
      end else if (p < 78) begin
        send_text(pick(" ,"));
      end else if (p < 85) begin
        send_eot();
      end else if (p < 97) begin
        send_text(8'($urandom_range(0, 255)));
      end else begin
        send_item(ACT_RULE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic random_default_text(int n, int max_len);
    random_text(n, WORD_START, WORD_BODY, "0123456789+-", "0123456789.", 8'h22, "\n",
                max_len);
  endtask

  // ---------------- tests ----------------

  task automatic test_default_tokens();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // word closed by a skipped byte
    send_text("a"); send_text("b"); send_text("1"); send_text(" ");
    // number closed by a symbol: two results from one transaction
    send_text("+"); send_text("9"); send_text(8'h0A);
    // string with a doubled quote, left pending at end of text
    send_text(8'h22); send_text("x"); send_text(8'h22); send_text(8'h22);
    send_text(8'h22); send_eot();
    // a skipped byte and end of text while idle
    send_text(8'h00); send_eot();
    // unterminated string holding a high byte
    send_text(8'h22); send_text(8'hFF); send_eot();
    wait_drained();
  endtask

  task automatic test_rule_writes();
    send_item(ACT_RULE, 8'h80, RULE_SY);
    send_text(8'h80);
    send_item(ACT_RULE, "#", RULE_WS);
    send_item(ACT_RULE, "$", RULE_WC);
    send_text("#"); send_text("$"); send_text("#");
    send_item(ACT_RULE, "'", RULE_QT);
    send_item(ACT_RULE, "@", RULE_NS);
    send_item(ACT_RULE, "~", RULE_NC);
    send_text("@"); send_text("~"); send_text("'"); send_eot();
    send_item(ACT_RULE, "@", RULE_IGN);
    send_text("@");
    send_item(ACT_RULE, "Z", 3'd7);
    send_text("Z"); send_eot();
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 300;
    random_default_text(50, 12);
    wait_drained();
  endtask

  task automatic test_limits();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_limits(15'd3, 15'd2, 15'd1);
    random_default_text(90, 10);
    load_limits(15'd0, 15'd0, 15'd0);
    random_default_text(60, 6);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_limits(15'd1, 15'h7FFF, 15'd5);
    random_default_text(80, 12);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_limits(15'h7FFF, 15'h7FFF, 15'h7FFF);
    random_default_text(90, 40);
    rx_idle = 1'b0;
    load_limits(15'd511, 15'd24575, 15'd127);
    random_default_text(100, 20);
    wait_drained();
  endtask

  // wipe the table and build a small alphabet of its own through rule writes
  task automatic test_custom_classes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_limits(15'd4, 15'd6, 15'd3);
    send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    for (int c = "a"; c <= "d"; c++) begin
      send_item(ACT_RULE, 8'(c), RULE_WS);
      send_item(ACT_RULE, 8'(c), RULE_WC);
    end
    send_item(ACT_RULE, "7", RULE_NS);
    send_item(ACT_RULE, "7", RULE_NC);
    send_item(ACT_RULE, "8", RULE_NC);
    send_item(ACT_RULE, "'", RULE_QT);
    send_item(ACT_RULE, ";", RULE_SY);
    random_text(110, "abcd", "abcd", "7", "78", "'", ";", 8);
    wait_drained();
  endtask

  initial begin
    items_sent      = 0;
    rx_hold         = 0;
    tx_idle         = 1'b0;
    rx_idle         = 1'b0;
    load_default_classes();
    scan       = SCAN_IDLE;
    tok_len    = 0;
    dropped    = 1'b0;
    word_lim   = 15'd511;
    string_lim = 15'd24575;
    number_lim = 15'd127;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_tokens();
    test_rule_writes();
    test_backpressure();
    test_limits();
    test_custom_classes();
    wait_drained();

    $display("run covered %0d input transactions and %0d output transactions",
             items_sent, results_checked);
    $display("limits from zero to full range, rule writes, table clear, output stall");
    if (errors == 0 && token_bytes_q.size() == 0) begin
      $display("char_class_text_tokenizer: match");
    end else begin
      $display("char_class_text_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cctt_pkg.sv
rtl/core/cctt_front.sv
rtl/core/cctt_queue.sv
rtl/core/cctt_back.sv
rtl/core/char_class_text_tokenizer.sv
rtl/core/cctt_checker.sv
bench/tb_char_class_text_tokenizer.sv
